// ===== sv/upi_pkg.sv =====
// ----------------------------------------------------------------------------
// upi_pkg
// Constants and helper functions for the unicycle pose integrator: register
// indexes, reset values, the CORDIC arctangent table and saturation.
// ----------------------------------------------------------------------------
package upi_pkg;

  // Opcodes of an input beat
  localparam logic OP_COMMAND = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // Configuration register indexes
  localparam logic REG_STEP_TIME   = 1'b0;
  localparam logic REG_STALE_LIMIT = 1'b1;

  localparam logic [15:0] STEP_TIME_RESET   = 16'd66;
  localparam logic [15:0] STALE_LIMIT_RESET = 16'd100;
  localparam logic [15:0] AGE_MAX           = 16'hFFFF;

  localparam int UPI_CORDIC_STEPS = 16;
  localparam int UPI_TABLE_LEN    = 24;

  // CORDIC datapath width: Q1.30 values with headroom for the rotations.
  localparam int UPI_XW = 34;
  localparam logic signed [UPI_XW-1:0] UPI_START_X = 34'sd652032874;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic signed [UPI_XW-1:0] atan_turns(input logic [4:0] idx);
    logic signed [UPI_XW-1:0] r;
    case (idx)
      5'd0:  r = 34'sd536870912;
      5'd1:  r = 34'sd316933406;
      5'd2:  r = 34'sd167458907;
      5'd3:  r = 34'sd85004756;
      5'd4:  r = 34'sd42667331;
      5'd5:  r = 34'sd21354465;
      5'd6:  r = 34'sd10679838;
      5'd7:  r = 34'sd5340245;
      5'd8:  r = 34'sd2670163;
      5'd9:  r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41721;
      5'd15: r = 34'sd20860;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2607;
      5'd19: r = 34'sd1303;
      5'd20: r = 34'sd651;
      5'd21: r = 34'sd325;
      5'd22: r = 34'sd162;
      5'd23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Clamp a 33-bit sum to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic [32:0] s);
    logic [31:0] r;
    if (s[32] != s[31]) begin
      r = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/unicycle_pose_integrator.sv =====
// ----------------------------------------------------------------------------
// unicycle_pose_integrator
// Planar pose integrator with a command watchdog: bit-serial products and an
// iterative CORDIC rotation advance x, y and heading on every fresh tick.
// ----------------------------------------------------------------------------
// The block takes one beat at a time. A command beat, or a tick that finds the
// command stale, goes straight to the output state and gives its result beat
// once the output register is free. A tick that moves the base first runs the
// rotation, CORDIC_STEPS steps capped at 24, and the speed-times-step products,
// which run together one bit of step_time per cycle until both are done; then
// the 32-bit distance is multiplied by cosine and sine one bit per cycle, and
// the update state writes the pose before the output state presents the result.
// in_ready is high only while no item is in progress; a finished result may
// wait on out_ready while the next beat is accepted. Configuration writes are
// taken at any time and should only be issued while the block is idle.

module unicycle_pose_integrator #(
  parameter int CORDIC_STEPS = upi_pkg::UPI_CORDIC_STEPS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               opcode,
  input  logic signed [15:0] linear_velocity,
  input  logic signed [20:0] angular_rate,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] position_x,
  output logic signed [31:0] position_y,
  output logic        [15:0] yaw_angle,
  output logic               stale,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic        [15:0] cfg_data
);

  localparam int XW         = upi_pkg::UPI_XW;
  localparam int DT_BITS    = 16;
  localparam int MUL_BITS   = 32;
  localparam int ROT_STEPS  = (CORDIC_STEPS < upi_pkg::UPI_TABLE_LEN) ?
                              CORDIC_STEPS : upi_pkg::UPI_TABLE_LEN;
  localparam int ROT_CYCLES = (ROT_STEPS > DT_BITS) ? ROT_STEPS : DT_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ROT  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state;
  logic [4:0] cnt;

  // Configuration and architectural state
  logic        [15:0] step_time;
  logic        [15:0] stale_limit;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic        [15:0] heading;
  logic signed [15:0] cmd_linear;
  logic signed [20:0] cmd_angular;
  logic        [15:0] cmd_age;
  logic               stale_q;

  // Working registers
  logic signed [XW-1:0] x_q, y_q, z_q;
  logic                 flip_q;
  logic signed [31:0]   vsh, dacc;
  logic signed [36:0]   wsh, wacc;
  logic        [15:0]   dtsh;
  logic        [31:0]   dsh;
  logic signed [34:0]   hx, hy;

  // Output register
  logic signed [31:0] out_x, out_y;
  logic        [15:0] out_yaw;
  logic               out_stale;

  logic accept;
  logic load_out;

  // Heading folded into a quarter turn either side of zero
  logic signed [16:0]   a17, af;
  logic                 fold;
  logic signed [XW-1:0] z_init;

  logic [15:0] age_next;
  logic        stale_next;

  logic signed [XW-1:0] xs, ys, at;
  logic signed [XW-1:0] x_next, y_next, z_next;

  logic               mb_neg;
  logic signed [35:0] xe, ye, add_x, add_y, hx_sum, hy_sum;

  logic signed [35:0] rx, ry;
  logic signed [27:0] dx, dy;
  logic        [32:0] sx, sy;
  logic        [36:0] rw;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign load_out   = (state == S_OUT) && (!out_valid || out_ready);
  assign position_x = out_x;
  assign position_y = out_y;
  assign yaw_angle  = out_yaw;
  assign stale      = out_stale;

  always_comb begin
    a17  = $signed({heading[15], heading});
    af   = a17;
    fold = 1'b0;
    if (a17 > 17'sd16384) begin
      af   = a17 - 17'sd32768;
      fold = 1'b1;
    end else if (a17 < -17'sd16384) begin
      af   = a17 + 17'sd32768;
      fold = 1'b1;
    end
    z_init = $signed({af[16], af, 16'h0000});
  end

  assign age_next   = (cmd_age == upi_pkg::AGE_MAX) ? cmd_age : cmd_age + 16'd1;
  assign stale_next = (age_next > stale_limit);

  // One CORDIC rotation per cycle
  always_comb begin
    xs = x_q >>> cnt;
    ys = y_q >>> cnt;
    at = upi_pkg::atan_turns(cnt);
    if (!z_q[XW-1]) begin
      x_next = x_q - ys;
      y_next = y_q + xs;
      z_next = z_q - at;
    end else begin
      x_next = x_q + ys;
      y_next = y_q - xs;
      z_next = z_q + at;
    end
  end

  // Shift-right multiplier: only the high half of the product is kept. The
  // final bit of the distance carries negative weight, and a folded heading
  // negates cosine and sine, so both flip the sign of the addend.
  always_comb begin
    mb_neg = (cnt == 5'(MUL_BITS - 1)) ^ flip_q;
    xe     = {{(36 - XW){x_q[XW-1]}}, x_q};
    ye     = {{(36 - XW){y_q[XW-1]}}, y_q};
    add_x  = dsh[0] ? (mb_neg ? -xe : xe) : '0;
    add_y  = dsh[0] ? (mb_neg ? -ye : ye) : '0;
    hx_sum = {hx[34], hx} + add_x;
    hy_sum = {hy[34], hy} + add_y;
  end

  // Round to 2^-16 m, saturate, and advance the heading
  always_comb begin
    rx = {hx[34], hx} + 36'sd128;
    ry = {hy[34], hy} + 36'sd128;
    dx = rx[35:8];
    dy = ry[35:8];
    sx = {pos_x[31], pos_x} + {{5{dx[27]}}, dx};
    sy = {pos_y[31], pos_y} + {{5{dy[27]}}, dy};
    rw = wacc + 37'sd32768;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_time   <= upi_pkg::STEP_TIME_RESET;
      stale_limit <= upi_pkg::STALE_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        upi_pkg::REG_STEP_TIME:   step_time   <= cfg_data;
        upi_pkg::REG_STALE_LIMIT: stale_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      pos_x       <= '0;
      pos_y       <= '0;
      heading     <= '0;
      cmd_linear  <= '0;
      cmd_angular <= '0;
      cmd_age     <= upi_pkg::AGE_MAX;
      stale_q     <= 1'b1;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready && !load_out) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (opcode == upi_pkg::OP_COMMAND) begin
              cmd_linear  <= linear_velocity;
              cmd_angular <= angular_rate;
              cmd_age     <= '0;
              stale_q     <= 1'b0;
              state       <= S_OUT;
            end else begin
              cmd_age <= age_next;
              stale_q <= stale_next;
              if (stale_next) begin
                state <= S_OUT;
              end else begin
                x_q    <= upi_pkg::UPI_START_X;
                y_q    <= '0;
                z_q    <= z_init;
                flip_q <= fold;
                vsh    <= {{16{cmd_linear[15]}}, cmd_linear};
                wsh    <= {{16{cmd_angular[20]}}, cmd_angular};
                dtsh   <= step_time;
                dacc   <= '0;
                wacc   <= '0;
                cnt    <= '0;
                state  <= S_ROT;
              end
            end
          end
        end
        S_ROT: begin
          // step_time is consumed LSB first; once it runs out the adds stop.
          if (dtsh[0]) begin
            dacc <= dacc + vsh;
            wacc <= wacc + wsh;
          end
          vsh  <= vsh <<< 1;
          wsh  <= wsh <<< 1;
          dtsh <= dtsh >> 1;
          if (cnt < 5'(ROT_STEPS)) begin
            x_q <= x_next;
            y_q <= y_next;
            z_q <= z_next;
          end
          if (cnt == 5'(ROT_CYCLES - 1)) begin
            cnt   <= '0;
            // The top bit of step_time may still be adding in this cycle.
            dsh   <= dtsh[0] ? dacc + vsh : dacc;
            hx    <= '0;
            hy    <= '0;
            state <= S_MUL;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_MUL: begin
          hx  <= hx_sum[35:1];
          hy  <= hy_sum[35:1];
          dsh <= dsh >> 1;
          if (cnt == 5'(MUL_BITS - 1)) begin
            cnt   <= '0;
            state <= S_UPD;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_UPD: begin
          pos_x   <= upi_pkg::sat32(sx);
          pos_y   <= upi_pkg::sat32(sy);
          heading <= heading + rw[31:16];
          state   <= S_OUT;
        end
        S_OUT: begin
          if (load_out) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_x     <= pos_x;
      out_y     <= pos_y;
      out_yaw   <= heading;
      out_stale <= stale_q;
    end
  end

endmodule

// ===== sv/upi_checker.sv =====
// ----------------------------------------------------------------------------
// upi_checker
// Port-level checks on the pose integrator, attached by a bind statement.
// ----------------------------------------------------------------------------
module upi_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] position_x,
  input logic signed [31:0] position_y,
  input logic        [15:0] yaw_angle,
  input logic               stale
);

  // A waiting result beat must hold its pose.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(position_x) &&
      $stable(position_y) && $stable(yaw_angle) && $stable(stale))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid straight after reset");

  // Items are worked one at a time: an accepted beat makes the block busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while an item is in progress");

  // A fresh result only appears after the block has been working on an item.
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result beat appeared without an item in progress");

endmodule

bind unicycle_pose_integrator upi_checker u_upi_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .position_x (position_x),
  .position_y (position_y),
  .yaw_angle  (yaw_angle),
  .stale      (stale)
);
